// ===== rtl/core/i2cs_pkg.sv =====
package i2cs_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned STEP_W      = 5;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_SEND     = 3'd2,
        ACT_RESTART  = 3'd3,
        ACT_RECEIVE  = 3'd4,
        ACT_ACK      = 3'd5,
        ACT_STOP     = 3'd6,
        ACT_FINISH   = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_WCOL     = 3'd1,
        ERR_BCOL     = 3'd2,
        ERR_OVERFLOW = 3'd3,
        ERR_NACK     = 3'd4,
        ERR_SEQUENCE = 3'd5,
        ERR_BUSY     = 3'd6
    } t_err;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WR_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND = 2'd2;

    // bus_status bit positions
    localparam int unsigned BS_WCOL = 0;
    localparam int unsigned BS_BCOL = 1;
    localparam int unsigned BS_OVF  = 2;
    localparam int unsigned BS_NACK = 3;

    localparam logic FUNC_LAUNCH = 1'b0;

    // transaction steps
    localparam logic [STEP_W-1:0] STEP_IDLE       = 5'd0;
    localparam logic [STEP_W-1:0] STEP_LAUNCH     = 5'd1;
    localparam logic [STEP_W-1:0] STEP_WR_ADDR    = 5'd2;
    localparam logic [STEP_W-1:0] STEP_CMD        = 5'd3;
    localparam logic [STEP_W-1:0] STEP_ROLL_LO    = 5'd4;
    localparam logic [STEP_W-1:0] STEP_ROLL_HI    = 5'd5;
    localparam logic [STEP_W-1:0] STEP_RESTART    = 5'd6;
    localparam logic [STEP_W-1:0] STEP_RD_ADDR    = 5'd7;
    localparam logic [STEP_W-1:0] STEP_RD_FIRST   = 5'd8;
    localparam logic [STEP_W-1:0] STEP_DATA_FIRST = 5'd9;
    localparam logic [STEP_W-1:0] STEP_HEADING    = 5'd11;
    localparam logic [STEP_W-1:0] STEP_RATE       = 5'd15;
    localparam logic [STEP_W-1:0] STEP_MAG_X      = 5'd19;
    localparam logic [STEP_W-1:0] STEP_MAG_Y      = 5'd23;
    localparam logic [STEP_W-1:0] STEP_DATA_LAST  = 5'd27;
    localparam logic [STEP_W-1:0] STEP_STOP       = 5'd28;
    localparam logic [STEP_W-1:0] STEP_DONE       = 5'd29;

    localparam logic signed [15:0] HEADING_WRAP = 16'sd3600;

    typedef struct packed {
        logic               func;
        logic signed [15:0] roll_angle;
        logic [3:0]         bus_status;
        logic [7:0]         rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         tx_byte;
        logic               ack_level;
        logic [2:0]         error_code;
        logic signed [15:0] heading;
        logic signed [15:0] heading_rate;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic               readings_valid;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic               is_launch;
        t_err               flag_err;
        logic               nack;
        logic signed [15:0] roll;
        logic [7:0]         rx;
    } t_cmd;

endpackage

// ===== rtl/core/i2cs_front.sv =====
module i2cs_front
    import i2cs_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.is_launch = (i_in_item.func == FUNC_LAUNCH);
        o_cmd.nack      = i_in_item.bus_status[BS_NACK];
        o_cmd.roll      = i_in_item.roll_angle;
        o_cmd.rx        = i_in_item.rx_byte;
        // collision and overflow flags in fixed priority
        if (i_in_item.bus_status[BS_WCOL]) begin
            o_cmd.flag_err = ERR_WCOL;
        end else if (i_in_item.bus_status[BS_BCOL]) begin
            o_cmd.flag_err = ERR_BCOL;
        end else if (i_in_item.bus_status[BS_OVF]) begin
            o_cmd.flag_err = ERR_OVERFLOW;
        end else begin
            o_cmd.flag_err = ERR_NONE;
        end
    end

endmodule

// ===== rtl/core/i2cs_queue.sv =====
module i2cs_queue
    import i2cs_pkg::*;
#(
    parameter int unsigned P_DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int unsigned AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    t_cmd          r_mem [P_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/i2cs_back.sv =====
module i2cs_back
    import i2cs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_cmd                 i_q_data,
    output logic                 o_pop,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item
);

    logic [7:0]         r_wr_addr, r_rd_addr, r_command;
    logic [STEP_W-1:0]  r_step,    n_step;
    logic [7:0]         r_low,     n_low;
    logic signed [15:0] r_roll,    n_roll;
    logic signed [15:0] r_heading, n_heading;
    logic signed [15:0] r_rate,    n_rate;
    logic signed [15:0] r_mag_x,   n_mag_x;
    logic signed [15:0] r_mag_y,   n_mag_y;
    logic signed [15:0] r_mag_z,   n_mag_z;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [STEP_W-1:0]  w_next;
    logic signed [15:0] w_word;
    t_action            w_act;
    t_err               w_err;
    logic [7:0]         w_tx;
    logic               w_ack;
    logic               w_valid;
    t_out_item          w_result;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_next = r_step + STEP_W'(1);
    assign w_word = $signed({i_q_data.rx, r_low});

    always_comb begin
        n_step    = r_step;
        n_low     = r_low;
        n_roll    = r_roll;
        n_heading = r_heading;
        n_rate    = r_rate;
        n_mag_x   = r_mag_x;
        n_mag_y   = r_mag_y;
        n_mag_z   = r_mag_z;
        w_act     = ACT_NONE;
        w_err     = ERR_NONE;
        w_tx      = '0;
        w_ack     = 1'b0;
        w_valid   = 1'b0;
        if (i_q_data.is_launch) begin
            if (r_step != STEP_IDLE) begin
                w_err = ERR_BUSY;
            end else begin
                n_roll = i_q_data.roll;
                n_step = STEP_LAUNCH;
                w_act  = ACT_START;
            end
        end else begin
            n_step = w_next;
            if (i_q_data.flag_err != ERR_NONE) begin
                w_err = i_q_data.flag_err;
            end else if (w_next == STEP_WR_ADDR) begin
                w_act = ACT_SEND;
                w_tx  = r_wr_addr;
            end else if (w_next >= STEP_CMD && w_next <= STEP_RESTART) begin
                if (i_q_data.nack) begin
                    w_err = ERR_NACK;
                end else if (w_next == STEP_CMD) begin
                    w_act = ACT_SEND;
                    w_tx  = r_command;
                end else if (w_next == STEP_ROLL_LO) begin
                    w_act = ACT_SEND;
                    w_tx  = r_roll[7:0];
                end else if (w_next == STEP_ROLL_HI) begin
                    w_act = ACT_SEND;
                    w_tx  = r_roll[15:8];
                end else begin
                    w_act = ACT_RESTART;
                end
            end else if (w_next == STEP_RD_ADDR) begin
                w_act = ACT_SEND;
                w_tx  = r_rd_addr;
            end else if (w_next == STEP_RD_FIRST) begin
                if (i_q_data.nack) begin
                    w_err = ERR_NACK;
                end else begin
                    w_act = ACT_RECEIVE;
                end
            end else if (w_next >= STEP_DATA_FIRST && w_next <= STEP_DATA_LAST) begin
                if (!w_next[0]) begin
                    w_act = ACT_RECEIVE;
                end else if (!w_next[1]) begin
                    // steps 9, 13, ...: low byte of a pair
                    n_low = i_q_data.rx;
                    w_act = ACT_ACK;
                end else begin
                    if (w_next == STEP_HEADING) begin
                        n_heading = w_word;
                    end else if (w_next == STEP_RATE) begin
                        n_rate = w_word;
                    end else if (w_next == STEP_MAG_X) begin
                        n_mag_x = w_word;
                    end else if (w_next == STEP_MAG_Y) begin
                        n_mag_y = w_word;
                    end else begin
                        n_mag_z = w_word;
                    end
                    w_act = ACT_ACK;
                    w_ack = (w_next == STEP_DATA_LAST);
                end
            end else if (w_next == STEP_STOP) begin
                w_act = ACT_STOP;
            end else if (w_next == STEP_DONE) begin
                if (r_heading[15]) begin
                    n_heading = r_heading + HEADING_WRAP;
                end
                w_act   = ACT_FINISH;
                w_valid = 1'b1;
                n_step  = STEP_IDLE;
            end else begin
                w_err = ERR_SEQUENCE;
            end
            if (w_err != ERR_NONE) begin
                n_step = STEP_IDLE;
                w_act  = ACT_FINISH;
                w_tx   = '0;
                w_ack  = 1'b0;
            end
        end
    end

    always_comb begin
        w_result.action         = w_act;
        w_result.tx_byte        = w_tx;
        w_result.ack_level      = w_ack;
        w_result.error_code     = w_err;
        w_result.heading        = n_heading;
        w_result.heading_rate   = n_rate;
        w_result.mag_x          = n_mag_x;
        w_result.mag_y          = n_mag_y;
        w_result.mag_z          = n_mag_z;
        w_result.readings_valid = w_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_addr   <= '0;
            r_rd_addr   <= '0;
            r_command   <= '0;
            r_step      <= STEP_IDLE;
            r_low       <= '0;
            r_roll      <= '0;
            r_heading   <= '0;
            r_rate      <= '0;
            r_mag_x     <= '0;
            r_mag_y     <= '0;
            r_mag_z     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WR_ADDR: r_wr_addr <= i_cfg_data;
                    CFG_RD_ADDR: r_rd_addr <= i_cfg_data;
                    CFG_COMMAND: r_command <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_pop) begin
                r_step    <= n_step;
                r_low     <= n_low;
                r_roll    <= n_roll;
                r_heading <= n_heading;
                r_rate    <= n_rate;
                r_mag_x   <= n_mag_x;
                r_mag_y   <= n_mag_y;
                r_mag_z   <= n_mag_z;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= w_result;
        end
    end

    // step 29 is never held: finish returns to idle in the same item
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_STOP)
        else $error("step counter out of range");

    a_flag_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_q_data.is_launch && i_q_data.flag_err != ERR_NONE
        |=> r_step == STEP_IDLE && r_out.action == ACT_FINISH)
        else $error("flagged event did not abort");

    a_valid_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.readings_valid
        |-> r_out.action == ACT_FINISH && r_out.error_code == ERR_NONE)
        else $error("readings_valid without clean finish");

    a_err_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.error_code != ERR_NONE
        |-> r_out.action == ACT_FINISH || r_out.action == ACT_NONE)
        else $error("error reported with a bus command");

endmodule

// ===== rtl/core/i2c_sensor_read_sequencer_unit.sv =====
// Step sequencer for an I2C write-then-read sensor transaction.
// Input channel (i_in_valid/o_in_ready, i_in_item): a launch item latches the roll
// angle and asks for a start condition; each bus event item advances one step and
// yields one bus command (send byte, repeated start, receive, ack, stop, finish).
// Output channel (o_out_valid/i_out_ready, o_out_item): exactly one item per input
// item, carrying the command, any error code and the current reading registers.
// Config channel (i_cfg_valid/o_cfg_ready): index 0 write address, 1 read address,
// 2 command byte; always ready, write only while the block is idle.
// An accepted item passes through the front queue, then the output register.
// Throughput: one item per cycle while i_out_ready stays high, set by the single-step update
// of the back end's step counter and reading registers.
// Reset clears the step counter to idle, all reading and config registers to zero.
// When the receiver stalls, the output register holds its item and the two-entry
// queue keeps taking input until full; o_in_ready then drops until space frees up.
module i2c_sensor_read_sequencer_unit
    import i2cs_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic w_push, w_pop, w_full, w_q_valid;
    t_cmd w_cmd_in, w_cmd_out;

    assign o_cfg_ready = 1'b1;

    i2cs_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    i2cs_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_cmd_out)
    );

    i2cs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_cmd_out),
        .o_pop       (w_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
